>>> rtl/mrt_pkg.sv
// ----------------------------------------------------------------------------
// mrt_pkg - shared types and constants for the range translate block
// Table geometry, command codes, sequencer states and the window entry layout.
// ----------------------------------------------------------------------------
package mrt_pkg;

  localparam int STAGES     = 8;
  localparam int WINDOWS    = 64;
  localparam int VALUE_BITS = 36;

  localparam int DEPTH   = STAGES * WINDOWS;
  localparam int STAGE_W = (STAGES > 1) ? $clog2(STAGES) : 1;
  localparam int SLOT_W  = (WINDOWS > 1) ? $clog2(WINDOWS) : 1;
  localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W   = $clog2(STAGES + 1);

  localparam int CMD_W = 2;
  localparam int CFG_W = 4;
  localparam logic [CFG_W-1:0] CFG_RESET = 4'd7;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_XLATE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

  localparam logic [VALUE_BITS-1:0] VAL_ONES = '1;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

  // Window as stored: end of range and offset are worked out at write time
  typedef struct packed {
    logic                  on;
    logic [VALUE_BITS-1:0] src;
    logic [VALUE_BITS:0]   lim;    // src + len
    logic [VALUE_BITS:0]   delta;  // dest - src, two's complement
  } win_entry_t;

  typedef struct packed {
    logic                  hit;
    logic                  sat;
    logic [VALUE_BITS-1:0] key;
  } cmp_res_t;

endpackage

>>> rtl/mrt_win_mem.sv
// ----------------------------------------------------------------------------
// mrt_win_mem - window table storage
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module mrt_win_mem (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [mrt_pkg::ADDR_W-1:0] wr_addr,
  input  mrt_pkg::win_entry_t       wr_data,
  input  logic                      rd_en,
  input  logic [mrt_pkg::ADDR_W-1:0] rd_addr,
  output mrt_pkg::win_entry_t       rd_data
);
  import mrt_pkg::*;

  win_entry_t mem [DEPTH];
  win_entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> rtl/mrt_cmp_unit.sv
// ----------------------------------------------------------------------------
// mrt_cmp_unit - shared window compare and offset unit
// Tests one window against the key and forms the remapped, saturated key.
// ----------------------------------------------------------------------------
module mrt_cmp_unit (
  input  logic                          chk,
  input  logic [mrt_pkg::VALUE_BITS-1:0] key,
  input  mrt_pkg::win_entry_t           entry,
  output mrt_pkg::cmp_res_t             res
);
  import mrt_pkg::*;

  logic [VALUE_BITS+1:0] sum;
  logic                  ge_src;
  logic                  lt_lim;
  logic                  over;

  // Offset add runs beside the two range compares
  assign sum    = {2'b00, key} + {entry.delta[VALUE_BITS], entry.delta};
  assign ge_src = (key >= entry.src);
  assign lt_lim = ({1'b0, key} < entry.lim);
  assign over   = |sum[VALUE_BITS+1:VALUE_BITS];

  assign res.hit = chk && entry.on && ge_src && lt_lim;
  assign res.sat = over;
  assign res.key = over ? VAL_ONES : sum[VALUE_BITS-1:0];

endmodule

>>> rtl/multistage_range_translate.sv
// ----------------------------------------------------------------------------
// multistage_range_translate - multistage range remap table
// Loads remap windows and walks keys through the stages in use.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats (in_valid / in_stall) carry a command: write a window, translate
//   a key, or clear the running minimum. Every beat gives exactly one result
//   beat (out_valid / out_stall). cfg_wr_en loads stages_used; write it only
//   while the block is idle.
//   Write, clear and unknown commands answer one cycle after acceptance.
//   A translate scans each stage in use slot by slot through the one shared
//   compare unit, fed by the single read port of the window table: a stage
//   ends at its first hit or once its last slot has been compared, and the
//   result is posted after the last stage in use.
//   One beat is worked on at a time; in_stall stays high while a translate
//   runs, and also while a result waits under out_stall.
//   After reset the table is swept once to clear every valid mark; during the
//   sweep in_stall is high (config writes are still taken).
//   When the receiver stalls, the result register holds its beat unchanged.
// ----------------------------------------------------------------------------
module multistage_range_translate (
  input  logic                           clk,
  input  logic                           rst_n,
  // configuration
  input  logic                           cfg_wr_en,
  input  logic [mrt_pkg::CFG_W-1:0]      cfg_wr_data,
  // input channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [mrt_pkg::CMD_W-1:0]      in_cmd,
  input  logic [2:0]                     in_stage_index,
  input  logic [5:0]                     in_slot_index,
  input  logic [mrt_pkg::VALUE_BITS-1:0] in_window_dest,
  input  logic [mrt_pkg::VALUE_BITS-1:0] in_window_src,
  input  logic [mrt_pkg::VALUE_BITS-1:0] in_window_len,
  input  logic                           in_window_on,
  input  logic [mrt_pkg::VALUE_BITS-1:0] in_key_in,
  // result channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [mrt_pkg::VALUE_BITS-1:0] out_key_out,
  output logic [mrt_pkg::VALUE_BITS-1:0] out_min_result,
  output logic [mrt_pkg::CNT_W-1:0]      out_stages_hit,
  output logic                           out_saturated
);
  import mrt_pkg::*;

  // Sequencer and bookkeeping
  state_t                state_r, state_nxt;
  logic [ADDR_W-1:0]     clr_addr_r, clr_addr_nxt;
  logic [CFG_W-1:0]      stages_used_r;
  logic [CNT_W-1:0]      used_eff;
  logic [CNT_W-1:0]      stage_r, stage_nxt;
  logic [SLOT_W-1:0]     slot_r, slot_nxt;
  logic                  iss_done_r, iss_done_nxt;
  logic                  chk_vld_r, chk_vld_nxt;
  logic                  chk_last_r, chk_last_nxt;
  logic [VALUE_BITS-1:0] key_r, key_nxt;
  logic [CNT_W-1:0]      hits_r, hits_nxt;
  logic                  sat_r, sat_nxt;
  logic [VALUE_BITS-1:0] min_r, min_nxt;

  // Result register
  logic                  out_valid_r, out_valid_nxt;
  logic [VALUE_BITS-1:0] out_key_r, out_key_nxt;
  logic [VALUE_BITS-1:0] out_min_r, out_min_nxt;
  logic [CNT_W-1:0]      out_hits_r, out_hits_nxt;
  logic                  out_sat_r, out_sat_nxt;

  // Table ports
  logic                  mem_wr_en;
  logic [ADDR_W-1:0]     mem_wr_addr;
  win_entry_t            mem_wr_data;
  logic                  mem_rd_en;
  logic [ADDR_W-1:0]     mem_rd_addr;
  win_entry_t            mem_rd_data;
  win_entry_t            win_wdata;

  cmp_res_t              cmp;

  logic                  in_acc;
  logic                  out_free;
  logic                  idx_ok;
  logic                  scan_adv;
  logic                  scan_end;
  logic                  clr_last;
  logic                  slot_last;

  // --------------------------------------------------------------------------
  // Handshake and decode
  // --------------------------------------------------------------------------
  // Result register frees up when empty or taken this cycle
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != ST_IDLE) || !out_free;
  assign in_acc   = in_valid && !in_stall;

  // Clamp the stage count to the number of stages in the table
  assign used_eff = (stages_used_r > CFG_W'(STAGES)) ? CNT_W'(STAGES)
                                                     : CNT_W'(stages_used_r);

  assign idx_ok = (32'(in_stage_index) < STAGES) && (32'(in_slot_index) < WINDOWS);

  assign clr_last  = (clr_addr_r == ADDR_W'(DEPTH - 1));
  assign slot_last = (slot_r == SLOT_W'(WINDOWS - 1));

  // A stage finishes on its first hit or after its last slot is compared
  assign scan_adv = (state_r == ST_SCAN) && chk_vld_r && (cmp.hit || chk_last_r);
  assign scan_end = scan_adv && ((stage_r + CNT_W'(1)) == used_eff);

  // Window as stored: precompute range end and offset on the write beat
  assign win_wdata.on    = in_window_on;
  assign win_wdata.src   = in_window_src;
  assign win_wdata.lim   = {1'b0, in_window_src} + {1'b0, in_window_len};
  assign win_wdata.delta = {1'b0, in_window_dest} - {1'b0, in_window_src};

  assign mem_rd_addr = ADDR_W'(32'(stage_r) * WINDOWS + 32'(slot_r));

  // --------------------------------------------------------------------------
  // Window table and shared compare unit
  // --------------------------------------------------------------------------
  mrt_win_mem u_win_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  mrt_cmp_unit u_cmp (
    .chk   (chk_vld_r),
    .key   (key_r),
    .entry (mem_rd_data),
    .res   (cmp)
  );

  // --------------------------------------------------------------------------
  // Next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc && (in_cmd == CMD_XLATE)) begin
          state_nxt = (used_eff == '0) ? ST_DONE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_end) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Datapath and sequencer outputs
  // --------------------------------------------------------------------------
  always_comb begin
    clr_addr_nxt = clr_addr_r;
    stage_nxt    = stage_r;
    slot_nxt     = slot_r;
    iss_done_nxt = iss_done_r;
    chk_vld_nxt  = 1'b0;
    chk_last_nxt = chk_last_r;
    key_nxt      = key_r;
    hits_nxt     = hits_r;
    sat_nxt      = sat_r;
    min_nxt      = min_r;

    out_valid_nxt = out_valid_r && out_stall;
    out_key_nxt   = out_key_r;
    out_min_nxt   = out_min_r;
    out_hits_nxt  = out_hits_r;
    out_sat_nxt   = out_sat_r;

    mem_wr_en   = 1'b0;
    mem_wr_addr = clr_addr_r;
    mem_wr_data = '0;
    mem_rd_en   = 1'b0;

    case (state_r)
      ST_CLEAR: begin
        // Sweep the table, dropping every valid mark
        mem_wr_en    = 1'b1;
        clr_addr_nxt = clr_addr_r + ADDR_W'(1);
      end
      ST_IDLE: begin
        if (in_acc) begin
          case (in_cmd)
            CMD_XLATE: begin
              key_nxt      = in_key_in;
              stage_nxt    = '0;
              slot_nxt     = '0;
              iss_done_nxt = 1'b0;
              hits_nxt     = '0;
              sat_nxt      = 1'b0;
            end
            CMD_WRITE: begin
              mem_wr_en   = idx_ok;
              mem_wr_addr = ADDR_W'(32'(in_stage_index) * WINDOWS + 32'(in_slot_index));
              mem_wr_data = win_wdata;
            end
            CMD_CLEAR: begin
              min_nxt = VAL_ONES;
            end
            default: begin
              // unknown command: answer like a write, change nothing
            end
          endcase
          if (in_cmd != CMD_XLATE) begin
            out_valid_nxt = 1'b1;
            out_key_nxt   = '0;
            out_min_nxt   = min_nxt;
            out_hits_nxt  = '0;
            out_sat_nxt   = 1'b0;
          end
        end
      end
      ST_SCAN: begin
        if (scan_adv) begin
          // Close this stage; any read already in flight is dropped
          if (cmp.hit) begin
            key_nxt  = cmp.key;
            hits_nxt = hits_r + CNT_W'(1);
            sat_nxt  = sat_r || cmp.sat;
          end
          stage_nxt    = stage_r + CNT_W'(1);
          slot_nxt     = '0;
          iss_done_nxt = 1'b0;
        end else if (!iss_done_r) begin
          // Issue the next slot read; it is compared in the following cycle
          mem_rd_en    = 1'b1;
          chk_vld_nxt  = 1'b1;
          chk_last_nxt = slot_last;
          slot_nxt     = slot_r + SLOT_W'(1);
          iss_done_nxt = slot_last;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          min_nxt       = (key_r < min_r) ? key_r : min_r;
          out_valid_nxt = 1'b1;
          out_key_nxt   = key_r;
          out_min_nxt   = min_nxt;
          out_hits_nxt  = hits_r;
          out_sat_nxt   = sat_r;
        end
      end
      default: begin
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_CLEAR;
      clr_addr_r    <= '0;
      stages_used_r <= CFG_RESET;
      chk_vld_r     <= 1'b0;
      iss_done_r    <= 1'b0;
      min_r         <= VAL_ONES;
      out_valid_r   <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      clr_addr_r <= clr_addr_nxt;
      if (cfg_wr_en) begin
        stages_used_r <= cfg_wr_data;
      end
      chk_vld_r   <= chk_vld_nxt;
      iss_done_r  <= iss_done_nxt;
      min_r       <= min_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload: no reset needed
  always_ff @(posedge clk) begin
    stage_r    <= stage_nxt;
    slot_r     <= slot_nxt;
    chk_last_r <= chk_last_nxt;
    key_r      <= key_nxt;
    hits_r     <= hits_nxt;
    sat_r      <= sat_nxt;
    out_key_r  <= out_key_nxt;
    out_min_r  <= out_min_nxt;
    out_hits_r <= out_hits_nxt;
    out_sat_r  <= out_sat_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_key_out    = out_key_r;
  assign out_min_result = out_min_r;
  assign out_stages_hit = out_hits_r;
  assign out_saturated  = out_sat_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
`ifndef NO_ASSERTIONS
  // A fresh result comes from a finished translate or a short command beat
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |->
      $past(state_r == ST_DONE) || $past(in_acc && (in_cmd != CMD_XLATE)))
    else $error("result appeared without a finished item");

  // Compare only on data from a read issued the cycle before
  a_cmp_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN && chk_vld_r) |-> $past(mem_rd_en))
    else $error("compare on stale table data");

  // Saturation needs at least one hit
  a_sat_needs_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_sat_r) |-> (out_hits_r != '0))
    else $error("saturation flagged with no stage hit");

  // Running minimum never above the key just posted
  a_min_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_key_r != '0)) |-> (out_min_r <= out_key_r))
    else $error("running minimum above posted key");
`endif

endmodule
